>>> hw/rtl/cgfr_pkg.sv
// ----------------------------------------------------------------------------
// cgfr_pkg: shared types, codes and font for the clock glyph frame renderer
// Holds display mode codes, glyph codes, the 8x8 font and the divide-by-ten
// helper used by the decode stage.
// ----------------------------------------------------------------------------
package cgfr_pkg;

    // display mode codes carried in s_tuser
    typedef logic [1:0] op_t;
    localparam op_t OP_TIME = 2'd0;
    localparam op_t OP_TEMP = 2'd1;
    localparam op_t OP_HUM  = 2'd2;

    // glyph codes; digits 0..9 use their own value
    typedef logic [3:0] glyph_t;
    localparam glyph_t GLYPH_DEGC  = 4'd10;
    localparam glyph_t GLYPH_DASH  = 4'd11;
    localparam glyph_t GLYPH_PCT   = 4'd12;
    localparam glyph_t GLYPH_BLANK = 4'd15;

    // display limits
    localparam logic [6:0] HOURS_MAX = 7'd99;
    localparam logic [6:0] TEMP_MAX  = 7'd50;
    localparam logic [6:0] HUM_MIN   = 7'd20;
    localparam logic [6:0] HUM_MAX   = 7'd90;
    localparam logic [6:0] TEN       = 7'd10;

    // segment numbering
    localparam int unsigned SEG_COUNT = 4;
    localparam logic [1:0]  SEG_LAST  = 2'd3;

    // row masks for the colon dots on rows 1, 2, 5 and 6
    localparam logic [63:0] COLON_LEFT  = 64'h0080_8000_0080_8000;
    localparam logic [63:0] COLON_RIGHT = 64'h0001_0100_0001_0100;
    localparam logic [63:0] ROW_LOW7    = 64'h7F7F_7F7F_7F7F_7F7F;
    localparam logic [63:0] ROW_HIGH7   = 64'hFEFE_FEFE_FEFE_FEFE;

    typedef logic [63:0] rows_t;

    // quotient and remainder of a 7-bit value by ten
    typedef struct packed {
        logic [3:0] quo;
        logic [3:0] rem;
    } div10_t;

    // reciprocal multiply, exact for all 7-bit values
    function automatic div10_t div10(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  q10;
        logic [6:0]  r;
        div10_t      res;
        prod    = {8'd0, v} * 15'd205;
        q       = prod[14:11];
        q10     = {q, 3'b000} + {2'b00, q, 1'b0};
        r       = v - q10;
        res.quo = q;
        res.rem = r[3:0];
        return res;
    endfunction

    // font rows, row 0 in the low byte, lsb is the leftmost led
    function automatic rows_t font_rows(input glyph_t g);
        rows_t rows;
        case (g)
            4'd0:        rows = 64'h3C7E_6666_6666_7E3C;
            4'd1:        rows = 64'h6060_6060_666E_7C78;
            4'd2:        rows = 64'h7E7E_063E_7C60_7E3E;
            4'd3:        rows = 64'h3E7E_607E_3E60_7E3E;
            4'd4:        rows = 64'h3030_7E7E_360C_1830;
            4'd5:        rows = 64'h3E7E_607E_3E06_7E7E;
            4'd6:        rows = 64'h3C7E_667E_3E06_3E3C;
            4'd7:        rows = 64'h0206_0C18_3060_7E7E;
            4'd8:        rows = 64'h3C7E_663C_3C66_7E3C;
            4'd9:        rows = 64'h3C7C_607C_7E66_7E3C;
            GLYPH_DEGC:  rows = 64'h7078_1818_1818_7B73;
            GLYPH_DASH:  rows = 64'h0000_007E_7E00_0000;
            GLYPH_PCT:   rows = 64'h43E7_4E1C_3872_E7C2;
            default:     rows = 64'h0;
        endcase
        return rows;
    endfunction

endpackage

>>> hw/rtl/clock_glyph_frame_renderer_core.sv
// Path: an accepted request passes the decode, font and output stage registers in
// turn; the four segments follow on consecutive cycles when m_tready holds.
// Flow: the result channel moves one segment per transaction, so each frame
// takes four transactions; the next request decodes while a frame drains.
// Reset: aresetn (synchronous, active low) clears all stage valid bits and the
// segment index; the glyph and row data registers are not reset.
// ----------------------------------------------------------------------------
// clock_glyph_frame_renderer_core: 32x8 led frame renderer
// Decodes a time, temperature or humidity request into four glyph codes,
// looks up the font and applies the colon layout in time mode, then sends
// the frame out as four 8x8 segment transactions.
// ----------------------------------------------------------------------------
module clock_glyph_frame_renderer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] hours, [13:7] minutes, [21:14] temperature, [28:22] humidity
    input  logic [31:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] segment_index, [65:2] segment_rows, [71:66] zero
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    // input fields
    logic [6:0] in_hours;
    logic [6:0] in_minutes;
    logic [7:0] in_temp;
    logic [6:0] in_hum;

    assign in_hours   = s_tdata[6:0];
    assign in_minutes = s_tdata[13:7];
    assign in_temp    = s_tdata[21:14];
    assign in_hum     = s_tdata[28:22];

    // stage registers
    logic                   a_valid_reg, a_valid_next;
    cgfr_pkg::glyph_t       a_glyph_reg [cgfr_pkg::SEG_COUNT];
    cgfr_pkg::glyph_t       a_glyph_next[cgfr_pkg::SEG_COUNT];
    logic                   a_time_reg, a_time_next;

    logic                   b_valid_reg, b_valid_next;
    cgfr_pkg::rows_t        b_rows_reg [cgfr_pkg::SEG_COUNT];
    cgfr_pkg::rows_t        b_rows_next[cgfr_pkg::SEG_COUNT];

    logic                   ser_valid_reg, ser_valid_next;
    logic [1:0]             ser_idx_reg, ser_idx_next;
    cgfr_pkg::rows_t        ser_rows_reg [cgfr_pkg::SEG_COUNT];
    cgfr_pkg::rows_t        ser_rows_next[cgfr_pkg::SEG_COUNT];

    // flow control
    logic ser_done;
    logic ser_load;
    logic b_free;
    logic a_move;

    assign ser_done = ser_valid_reg && m_tready && (ser_idx_reg == cgfr_pkg::SEG_LAST);
    assign ser_load = b_valid_reg && (!ser_valid_reg || ser_done);
    assign b_free   = !b_valid_reg || ser_load;
    assign a_move   = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || b_free;

    // decode stage: clamp, split into digits, pick glyph codes
    logic [6:0]             hours_sat;
    logic [6:0]             value;
    cgfr_pkg::div10_t       val_div;
    cgfr_pkg::div10_t       min_div;
    logic [3:0]             min_tens;
    logic                   temp_ok;
    logic                   hum_ok;
    cgfr_pkg::glyph_t       tens_glyph;

    always_comb begin
        hours_sat  = (in_hours > cgfr_pkg::HOURS_MAX) ? cgfr_pkg::HOURS_MAX : in_hours;
        temp_ok    = !in_temp[7] && (in_temp[6:0] <= cgfr_pkg::TEMP_MAX);
        hum_ok     = (in_hum >= cgfr_pkg::HUM_MIN) && (in_hum <= cgfr_pkg::HUM_MAX);
        unique case (s_tuser)
            cgfr_pkg::OP_TIME: value = hours_sat;
            cgfr_pkg::OP_TEMP: value = in_temp[6:0];
            cgfr_pkg::OP_HUM:  value = in_hum;
            default:           value = 7'd0;
        endcase
        val_div    = cgfr_pkg::div10(value);
        min_div    = cgfr_pkg::div10(in_minutes);
        // minutes above 99 keep only the tens digit modulo ten
        min_tens   = (min_div.quo >= 4'd10) ? (min_div.quo - 4'd10) : min_div.quo;
        // no leading zero on the left digit
        tens_glyph = (value >= cgfr_pkg::TEN) ? val_div.quo : cgfr_pkg::GLYPH_BLANK;
    end

    always_comb begin
        for (int s = 0; s < cgfr_pkg::SEG_COUNT; s++) begin
            a_glyph_next[s] = cgfr_pkg::GLYPH_BLANK;
        end
        a_time_next = 1'b0;
        unique case (s_tuser)
            cgfr_pkg::OP_TIME: begin
                a_glyph_next[0] = tens_glyph;
                a_glyph_next[1] = val_div.rem;
                a_glyph_next[2] = min_tens;
                a_glyph_next[3] = min_div.rem;
                a_time_next     = 1'b1;
            end
            cgfr_pkg::OP_TEMP: begin
                a_glyph_next[3] = cgfr_pkg::GLYPH_DEGC;
                a_glyph_next[1] = temp_ok ? tens_glyph  : cgfr_pkg::GLYPH_DASH;
                a_glyph_next[2] = temp_ok ? val_div.rem : cgfr_pkg::GLYPH_DASH;
            end
            cgfr_pkg::OP_HUM: begin
                a_glyph_next[3] = cgfr_pkg::GLYPH_PCT;
                a_glyph_next[1] = hum_ok ? tens_glyph  : cgfr_pkg::GLYPH_DASH;
                a_glyph_next[2] = hum_ok ? val_div.rem : cgfr_pkg::GLYPH_DASH;
            end
            default: begin
                a_time_next = 1'b0;
            end
        endcase
    end

    assign a_valid_next = (s_tvalid && s_tready) || (a_valid_reg && !b_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            a_glyph_reg <= a_glyph_next;
            a_time_reg  <= a_time_next;
        end
    end

    // font stage: look up glyphs; in time mode shift the middle pair apart, add colon
    always_comb begin
        cgfr_pkg::rows_t raw [cgfr_pkg::SEG_COUNT];
        for (int s = 0; s < cgfr_pkg::SEG_COUNT; s++) begin
            raw[s] = cgfr_pkg::font_rows(a_glyph_reg[s]);
        end
        b_rows_next = raw;
        if (a_time_reg) begin
            b_rows_next[1] = ((raw[1] >> 1) & cgfr_pkg::ROW_LOW7) | cgfr_pkg::COLON_LEFT;
            b_rows_next[2] = ((raw[2] << 1) & cgfr_pkg::ROW_HIGH7) | cgfr_pkg::COLON_RIGHT;
        end
    end

    assign b_valid_next = a_move || (b_valid_reg && !ser_load);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_free) begin
            b_rows_reg <= b_rows_next;
        end
    end

    // output stage: shift out one segment per transaction
    always_comb begin
        ser_valid_next = ser_valid_reg;
        ser_idx_next   = ser_idx_reg;
        ser_rows_next  = ser_rows_reg;
        if (ser_load) begin
            ser_valid_next = 1'b1;
            ser_idx_next   = 2'd0;
            ser_rows_next  = b_rows_reg;
        end else if (ser_done) begin
            ser_valid_next = 1'b0;
        end else if (ser_valid_reg && m_tready) begin
            ser_idx_next = ser_idx_reg + 2'd1;
            for (int s = 0; s < cgfr_pkg::SEG_COUNT - 1; s++) begin
                ser_rows_next[s] = ser_rows_reg[s + 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= 2'd0;
        end else begin
            ser_valid_reg <= ser_valid_next;
            ser_idx_reg   <= ser_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        ser_rows_reg <= ser_rows_next;
    end

    // result channel
    assign m_tvalid = ser_valid_reg;
    assign m_tlast  = (ser_idx_reg == cgfr_pkg::SEG_LAST);
    assign m_tdata  = {6'd0, ser_rows_reg[0], ser_idx_reg};

    // segment numbers step by one within a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (ser_idx_reg == $past(ser_idx_reg) + 2'd1)))
        else $error("segment index did not advance");

    // a waiting frame follows the last segment without a gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && b_valid_reg) |=>
            (m_tvalid && (ser_idx_reg == 2'd0)))
        else $error("queued frame not loaded after last segment");

    // a new frame only loads when the previous one has fully drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ser_load && ser_valid_reg) |-> (m_tready && m_tlast))
        else $error("frame overwritten before last segment was taken");

    // a decoded request never waits on a free font stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !b_valid_reg) |=> (b_valid_reg || !$past(a_valid_reg)))
        else $error("decode stage stalled with an empty font stage");

endmodule
